@@ src/agt_pkg.sv @@
// Shared types and constants for the anagram group table.
// No dependencies.
`timescale 1ns / 1ps
package agt_pkg;
   localparam int NBINS = 26;
   localparam int BIN_W = 6;
   localparam int KEY_W = NBINS * BIN_W;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NOT_FOUND  = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_GROUP_FULL = 3'd3,
      ST_TOO_LONG   = 3'd4
   } status_type;

   // one finished word handed from front to back
   typedef struct packed {
      logic    mode;
      logic    too_long;
      logic [15:0] tag;
      key_type key;
   } word_type;
endpackage

@@ src/agt_front.sv @@
// Front end: accumulates letters into the key histogram and pushes finished words.
// Depends on agt_pkg.
`timescale 1ns / 1ps
module agt_front #(
   parameter int MAX_WORD = 50
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [4:0]        req_letter,
   input  logic              req_word_end,
   input  logic [15:0]       req_word_tag,
   output logic              push,
   output agt_pkg::word_type push_word,
   input  logic              q_full
);
   import agt_pkg::*;
   localparam int LEN_W = $clog2(MAX_WORD + 2);

   logic [BIN_W-1:0] counts_ff [NBINS];
   logic [BIN_W-1:0] counts_in [NBINS];
   logic [LEN_W-1:0] len_ff, len_in;
   logic acc;

   assign req_stall = q_full;
   assign acc = req_valid && !q_full;

   always_comb begin
      for (int i = 0; i < NBINS; i++) counts_in[i] = counts_ff[i];
      len_in = len_ff;
      if (req_letter < 5'(NBINS) && len_ff <= LEN_W'(MAX_WORD)) begin
         len_in = len_ff + 1'b1;
         if (len_in <= LEN_W'(MAX_WORD))
            counts_in[req_letter] = counts_ff[req_letter] + 1'b1;
      end
   end

   always_comb begin
      push_word.mode = req_mode;
      push_word.too_long = len_in > LEN_W'(MAX_WORD);
      push_word.tag = req_word_tag;
      for (int i = 0; i < NBINS; i++) push_word.key[i*BIN_W +: BIN_W] = counts_in[i];
   end
   assign push = acc && req_word_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int i = 0; i < NBINS; i++) counts_ff[i] <= '0;
      end else if (acc) begin
         if (req_word_end) begin
            len_ff <= '0;
            for (int i = 0; i < NBINS; i++) counts_ff[i] <= '0;
         end else begin
            len_ff <= len_in;
            for (int i = 0; i < NBINS; i++) counts_ff[i] <= counts_in[i];
         end
      end
   end
endmodule

@@ src/agt_queue.sv @@
// Small word FIFO between front end and back end.
// Depends on agt_pkg.
`timescale 1ns / 1ps
module agt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  agt_pkg::word_type push_word,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output agt_pkg::word_type head
);
   import agt_pkg::*;
   localparam int DEPTH = 4;
   word_type    slot_ff [DEPTH];
   logic [1:0]  wr_ff, rd_ff;
   logic [2:0]  cnt_ff;

   assign full = cnt_ff == 3'(DEPTH);
   assign not_empty = cnt_ff != 3'd0;
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_word;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

@@ src/agt_back.sv @@
// Back end: searches stored keys, appends tags, streams query groups.
// Depends on agt_pkg.
`timescale 1ns / 1ps
module agt_back #(
   parameter int TABLE_ENTRIES = 256,
   parameter int GROUP_DEPTH   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  agt_pkg::word_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_match_tag,
   output logic              rsp_last
);
   import agt_pkg::*;
   localparam int EW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = $clog2(GROUP_DEPTH + 1);
   localparam int GW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_RD = 6'b000010, S_CMP = 6'b000100,
      S_DEC = 6'b001000, S_TRD = 6'b010000, S_TOUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   key_type   key_mem  [TABLE_ENTRIES];
   logic [SW-1:0] size_mem [TABLE_ENTRIES];
   logic [15:0]   tag_mem  [TABLE_ENTRIES * (2 ** GW)];

   logic [EW-1:0] used_ff;
   logic [EW-1:0] idx_ff;
   key_type       rkey_ff;
   logic [SW-1:0] rsize_ff;
   logic [15:0]   rtag_ff;
   logic [GW-1:0] j_ff;
   logic [SW-1:0] sz_ff;
   logic [AW-1:0] grp_ff;
   logic          found_ff;

   logic          ov_ff;
   logic [2:0]    ost_ff;
   logic [15:0]   otag_ff;
   logic          olast_ff;
   logic          out_free;

   assign rsp_valid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_match_tag = otag_ff;
   assign rsp_last = olast_ff;
   assign out_free = !ov_ff || !rsp_stall;

   logic [AW-1:0] idx_a, used_a;
   assign idx_a = idx_ff[AW-1:0];
   assign used_a = used_ff[AW-1:0];

   always_ff @(posedge clock) begin
      rkey_ff  <= key_mem[idx_a];
      rsize_ff <= size_mem[idx_a];
      rtag_ff  <= tag_mem[{grp_ff, GW'(0)} + (AW+GW)'(j_ff)];
   end

   logic emit;
   logic [2:0] est;
   logic [15:0] etag;
   logic elast;

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      emit = 1'b0;
      est = ST_OK;
      etag = '0;
      elast = 1'b1;
      case (state_ff)
         S_IDLE: if (not_empty) state_in = S_RD;
         S_RD:   state_in = S_CMP;
         S_CMP:  begin
            if (found_ff || idx_ff >= used_ff) state_in = S_DEC;
            else state_in = S_RD;
         end
         S_DEC: if (out_free) begin
            pop = 1'b1;
            emit = 1'b1;
            state_in = S_IDLE;
            if (head.too_long) est = ST_TOO_LONG;
            else if (head.mode == 1'b0) begin
               if (found_ff) begin
                  if (rsize_ff >= SW'(GROUP_DEPTH)) est = ST_GROUP_FULL;
                  else etag = head.tag;
               end else if (used_ff >= EW'(TABLE_ENTRIES)) est = ST_TABLE_FULL;
               else etag = head.tag;
            end else if (!found_ff) est = ST_NOT_FOUND;
            else begin
               emit = 1'b0;
               pop = 1'b0;
               state_in = S_TRD;
            end
         end
         S_TRD: state_in = S_TOUT;
         S_TOUT: if (out_free) begin
            emit = 1'b1;
            etag = rtag_ff;
            elast = (SW'(j_ff) + 1'b1) == sz_ff;
            if (elast) begin
               pop = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_TRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DEC && out_free && !head.too_long && head.mode == 1'b0) begin
         if (found_ff && rsize_ff < SW'(GROUP_DEPTH)) begin
            tag_mem[{grp_ff, GW'(0)} + (AW+GW)'(rsize_ff)] <= head.tag;
            size_mem[grp_ff] <= rsize_ff + 1'b1;
         end else if (!found_ff && used_ff < EW'(TABLE_ENTRIES)) begin
            key_mem[used_a] <= head.key;
            tag_mem[{used_a, GW'(0)}] <= head.tag;
            size_mem[used_a] <= SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ost_ff <= est;
         otag_ff <= etag;
         olast_ff <= elast;
      end
      case (state_ff)
         S_IDLE: begin
            idx_ff <= '0;
            found_ff <= 1'b0;
         end
         S_CMP: begin
            if (idx_ff < used_ff && rkey_ff == head.key) begin
               found_ff <= 1'b1;
               grp_ff <= idx_a;
            end else if (idx_ff < used_ff) idx_ff <= idx_ff + 1'b1;
            j_ff <= '0;
         end
         S_DEC: sz_ff <= rsize_ff;
         S_TOUT: if (out_free) j_ff <= j_ff + 1'b1;
         default: ;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         if (state_ff == S_DEC && out_free && !head.too_long && head.mode == 1'b0
             && !found_ff && used_ff < EW'(TABLE_ENTRIES))
            used_ff <= used_ff + 1'b1;
      end
   end
endmodule

@@ src/anagram_group_table.sv @@
// Anagram group table. The front end adds each letter transfer to its key
// histogram; a finished word goes through a four-deep queue to the back end.
// The back end leaves idle, then reads and compares the stored group keys one
// by one (key read, compare) until a hit or the last stored group. It then
// sends one plain result, or reads and emits each group member in turn (one
// tag memory read port). Letter input stalls only when the queue is full.
// Memories start undefined; no clearing pass is run after reset.
// Depends on agt_pkg, agt_front, agt_queue, agt_back.
`timescale 1ns / 1ps
module anagram_group_table #(
   parameter int TABLE_ENTRIES = 256,
   parameter int GROUP_DEPTH   = 32,
   parameter int MAX_WORD      = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [4:0]  req_letter,
   input  logic        req_word_end,
   input  logic [15:0] req_word_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_match_tag,
   output logic        rsp_last
);
   import agt_pkg::*;
   logic push, q_full, pop, not_empty;
   word_type push_word, head;

   agt_front #(.MAX_WORD(MAX_WORD)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_letter,
      .req_word_end, .req_word_tag, .push, .push_word, .q_full
   );
   agt_queue u_queue (
      .clock, .reset, .push, .push_word, .full(q_full), .pop, .not_empty, .head
   );
   agt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .GROUP_DEPTH(GROUP_DEPTH)) u_back (
      .clock, .reset, .not_empty, .head, .pop, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_match_tag, .rsp_last
   );
endmodule

@@ tb/anagram_group_table_tb.sv @@
// Self-checking testbench for anagram_group_table: a queue-fed driver, a stalling
// receiver, a monitor and an in-bench predictor of groups keyed by letter histograms.
// Depends on agt_pkg and the anagram_group_table RTL.
`timescale 1ns / 1ps
module anagram_group_table_tb;
   import agt_pkg::*;

   localparam int TABLE_ENTRIES = 256;
   localparam int GROUP_DEPTH   = 32;
   localparam int MAX_WORD      = 50;
   localparam int CYCLE_LIMIT   = 800000;

   typedef struct {
      logic        mode;
      logic [4:0]  letter;
      logic        word_end;
      logic [15:0] word_tag;
   } letter_item_type;

   typedef struct {
      status_type  status;
      logic [15:0] tag;
      logic        last;
   } group_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [4:0]  req_letter = '0;
   logic        req_word_end = 1'b0;
   logic [15:0] req_word_tag = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_match_tag;
   logic        rsp_last;

   letter_item_type  pending_letters[$];
   group_result_type expected_results[$];

   // predictor state
   key_type     word_key;
   int          word_len;
   int          groups_used;
   key_type     group_keys[TABLE_ENTRIES];
   int          group_count[TABLE_ENTRIES];
   logic [15:0] group_members[TABLE_ENTRIES][GROUP_DEPTH];

   int  mismatches = 0;
   int  cycles = 0;
   int  sent = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  req_took = 0;

   anagram_group_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .GROUP_DEPTH(GROUP_DEPTH), .MAX_WORD(MAX_WORD)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_letter(req_letter), .req_word_end(req_word_end), .req_word_tag(req_word_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_match_tag(rsp_match_tag), .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic group_result_type mk_result(status_type st, logic [15:0] tg,
                                                  logic lst);
      group_result_type r;
      r.status = st;
      r.tag    = tg;
      r.last   = lst;
      return r;
   endfunction

   function automatic int find_group_of_key();
      for (int e = 0; e < groups_used; e++)
         if (group_keys[e] == word_key) return e;
      return -1;
   endfunction

   task automatic predict_letter(letter_item_type it);
      int g;
      if (it.letter < NBINS && word_len <= MAX_WORD) begin
         word_len++;
         if (word_len <= MAX_WORD)
            word_key[it.letter*BIN_W +: BIN_W] = word_key[it.letter*BIN_W +: BIN_W] + 1'b1;
      end
      if (!it.word_end) return;
      if (word_len > MAX_WORD) begin
         expected_results.push_back(mk_result(ST_TOO_LONG, '0, 1'b1));
      end else begin
         g = find_group_of_key();
         if (it.mode == 1'b0) begin
            if (g >= 0) begin
               if (group_count[g] >= GROUP_DEPTH) begin
                  expected_results.push_back(mk_result(ST_GROUP_FULL, '0, 1'b1));
               end else begin
                  group_members[g][group_count[g]] = it.word_tag;
                  group_count[g]++;
                  expected_results.push_back(mk_result(ST_OK, it.word_tag, 1'b1));
               end
            end else if (groups_used >= TABLE_ENTRIES) begin
               expected_results.push_back(mk_result(ST_TABLE_FULL, '0, 1'b1));
            end else begin
               group_keys[groups_used]       = word_key;
               group_members[groups_used][0] = it.word_tag;
               group_count[groups_used]      = 1;
               groups_used++;
               expected_results.push_back(mk_result(ST_OK, it.word_tag, 1'b1));
            end
         end else if (g >= 0) begin
            for (int j = 0; j < group_count[g]; j++)
               expected_results.push_back(mk_result(ST_OK, group_members[g][j],
                                                    j == group_count[g] - 1));
         end else begin
            expected_results.push_back(mk_result(ST_NOT_FOUND, '0, 1'b1));
         end
      end
      word_key = '0;
      word_len = 0;
   endtask

   task automatic put_letter(logic md, logic [4:0] lt, logic fin, logic [15:0] tg);
      letter_item_type it;
      it.mode     = md;
      it.letter   = lt;
      it.word_end = fin;
      it.word_tag = tg;
      pending_letters.push_back(it);
      predict_letter(it);
   endtask

   // random word of n letters from 0..top; earlier letters carry noise in mode and tag
   task automatic put_word(logic md, int n, int top, int noise_pct);
      logic [4:0] lt;
      for (int i = 0; i < n; i++) begin
         lt = 5'($urandom_range(0, top));
         if ($urandom_range(0, 99) < noise_pct) lt = 5'($urandom_range(26, 31));
         put_letter((i == n - 1) ? md : 1'($urandom), lt, i == n - 1, 16'($urandom));
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   always @(posedge clock) req_took <= req_valid && !req_stall;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the stalled transfer
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_letters.size() > 0) begin
         req_valid    <= 1'b1;
         req_mode     <= pending_letters[0].mode;
         req_letter   <= pending_letters[0].letter;
         req_word_end <= pending_letters[0].word_end;
         req_word_tag <= pending_letters[0].word_tag;
         void'(pending_letters.pop_front());
         sent     <= sent + 1;
         send_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && sent >= 80) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall  <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      group_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status=%0d tag=%h last=%b",
                        rsp_status, rsp_match_tag, rsp_last);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_match_tag !== want.tag ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status=%0d tag=%h last=%b, got %0d %h %b",
                           want.status, want.tag, want.last,
                           rsp_status, rsp_match_tag, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      word_key    = '0;
      word_len    = 0;
      groups_used = 0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: anagram pair, miss, empty key, extremes of the fields
      put_letter(1'b0, 5'd0, 1'b0, 16'h0000);
      put_letter(1'b0, 5'd25, 1'b1, 16'hFFFF);
      put_letter(1'b1, 5'd25, 1'b0, 16'h1234);
      put_letter(1'b1, 5'd0, 1'b1, 16'h0000);
      put_letter(1'b0, 5'd25, 1'b0, 16'hFFFF);
      put_letter(1'b0, 5'd0, 1'b1, 16'h0000);
      put_letter(1'b1, 5'd0, 1'b1, 16'hAAAA);
      put_letter(1'b1, 5'd26, 1'b1, 16'h5555);
      put_letter(1'b0, 5'd31, 1'b1, 16'h5A5A);
      put_letter(1'b0, 5'd27, 1'b0, 16'hFFFF);
      put_letter(1'b1, 5'd30, 1'b1, 16'h0000);
      put_letter(1'b0, 5'd1, 1'b0, 16'h0001);
      put_letter(1'b0, 5'd31, 1'b0, 16'h0002);
      put_letter(1'b0, 5'd2, 1'b1, 16'h8000);
      put_letter(1'b1, 5'd2, 1'b0, 16'h0000);
      put_letter(1'b0, 5'd1, 1'b1, 16'h7FFF);
      put_letter(1'b1, 5'd7, 1'b1, 16'h0000);
      put_word(1'b0, 51, 25, 0);
      put_word(1'b1, 52, 25, 0);
      put_word(1'b0, 50, 0, 0);

      // random words over a small alphabet so groups and matches build up
      repeat (60)
         put_word(1'($urandom_range(0, 99) < 40), $urandom_range(1, 4), 3, 8);
      // fill one group past its depth, then read it back
      repeat (GROUP_DEPTH + 2) put_letter(1'b0, 5'd25, 1'b1, 16'($urandom));
      put_letter(1'b1, 5'd25, 1'b1, 16'($urandom));
      repeat (20) put_word(1'($urandom), $urandom_range(1, 3), 25, 5);

      wait (pending_letters.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (1500) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
